/* src/pmgf_pkg.sv */
`default_nettype none
package pmgf_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 48;

  localparam logic [CfgIdxW-1:0] REG_CENTRE_X      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CENTRE_Y      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PLANET_RADIUS = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_PLANET_MASS   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_GRAVITY_SCALE = 3'd4;

  typedef struct packed {
    logic [31:0] centre_x;
    logic [31:0] centre_y;
    logic [30:0] planet_radius;
    logic [39:0] planet_mass;
    logic [47:0] gravity_scale;
  } pmgf_cfg_t;

  typedef struct packed {
    logic [47:0] force_x;
    logic [47:0] force_y;
    logic        saturated;
  } pmgf_res_t;

endpackage
`default_nettype wire

/* src/pmgf_if.sv */
`default_nettype none
interface pmgf_probe_if;
  logic        valid;
  logic        ready;
  logic [31:0] probe_x;
  logic [31:0] probe_y;
  logic [39:0] probe_mass;

  modport source(output valid, output probe_x, output probe_y, output probe_mass, input ready);
  modport sink(input valid, input probe_x, input probe_y, input probe_mass, output ready);
endinterface

interface pmgf_force_if;
  logic        valid;
  logic        ready;
  logic [47:0] force_x;
  logic [47:0] force_y;
  logic        saturated;

  modport source(output valid, output force_x, output force_y, output saturated, input ready);
  modport sink(input valid, input force_x, input force_y, input saturated, output ready);
endinterface
`default_nettype wire

/* src/pmgf_core.sv */
`default_nettype none
module pmgf_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  pmgf_pkg::pmgf_cfg_t cfg,
  input  logic                in_valid,
  input  logic [31:0]         probe_x,
  input  logic [31:0]         probe_y,
  input  logic [39:0]         probe_mass,
  output logic                res_valid,
  output pmgf_pkg::pmgf_res_t res
);
  import pmgf_pkg::*;

  localparam int QBits  = 81;
  localparam int SqBits = 34;
  localparam int CBits  = 48;

  typedef struct packed {
    logic [32:0] adx;
    logic [32:0] ady;
    logic        nx;
    logic        ny;
  } side_t;

  typedef struct packed {
    logic             v;
    logic [127:0]     rem;
    logic [QBits-1:0] q;
    logic             cap;
    logic [73:0]      den;
    logic [65:0]      srem;
    logic [SqBits-1:0] sres;
    logic             zero;
    side_t            side;
  } div_t;

  typedef struct packed {
    logic              v;
    logic [81:0]       remx;
    logic [CBits-1:0]  qx;
    logic              ovfx;
    logic [81:0]       remy;
    logic [CBits-1:0]  qy;
    logic              ovfy;
    logic [SqBits-1:0] rr;
    logic              nx;
    logic              ny;
    logic              zero;
  } comp_t;

  // offsets
  logic        v1;
  logic [32:0] dx1, dy1;
  logic [39:0] m1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1 <= {cfg.centre_x[31], cfg.centre_x} - {probe_x[31], probe_x};
      dy1 <= {cfg.centre_y[31], cfg.centre_y} - {probe_y[31], probe_y};
      m1  <= probe_mass;
    end
  end

  // magnitudes
  logic        v2;
  side_t       sd2;
  logic [39:0] m2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd2.adx <= dx1[32] ? (~dx1 + 33'd1) : dx1;
      sd2.ady <= dy1[32] ? (~dy1 + 33'd1) : dy1;
      sd2.nx  <= dx1[32];
      sd2.ny  <= dy1[32];
      m2      <= m1;
    end
  end

  // squares, G*M halves, radius squared
  logic        v3;
  side_t       sd3;
  logic [39:0] m3;
  logic [65:0] sqx3, sqy3;
  logic [63:0] gml3, gmh3;
  logic [61:0] p2_3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd3  <= sd2;
      m3   <= m2;
      sqx3 <= 66'(sd2.adx) * 66'(sd2.adx);
      sqy3 <= 66'(sd2.ady) * 66'(sd2.ady);
      gml3 <= 64'(cfg.gravity_scale[23:0]) * 64'(cfg.planet_mass);
      gmh3 <= 64'(cfg.gravity_scale[47:24]) * 64'(cfg.planet_mass);
      p2_3 <= 62'(cfg.planet_radius) * 62'(cfg.planet_radius);
    end
  end

  // r^2 and G*M
  logic        v4;
  side_t       sd4;
  logic [39:0] m4;
  logic [65:0] r2_4;
  logic [87:0] gm4;
  logic [61:0] p2_4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd4  <= sd3;
      m4   <= m3;
      r2_4 <= sqx3 + sqy3;
      gm4  <= (88'(gmh3) << 24) + 88'(gml3);
      p2_4 <= p2_3;
    end
  end

  // numerator partial products, divisor select
  logic        v5;
  side_t       sd5;
  logic [61:0] pp5 [4];
  logic [73:0] den5;
  logic [65:0] r2_5;
  logic        zero5;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd5   <= sd4;
      r2_5  <= r2_4;
      zero5 <= (r2_4 == '0);
      for (int k = 0; k < 4; k++) begin
        pp5[k] <= 62'(gm4[22*k +: 22]) * 62'(m4);
      end
      // outside: 256*r2, inside: 2560*P^2
      den5 <= (r2_4 > 66'(p2_4)) ? (74'(r2_4) << 8)
                                 : ((74'(p2_4) << 11) + (74'(p2_4) << 9));
    end
  end

  // numerator sums
  logic         v6, v7;
  side_t        sd6, sd7;
  logic [83:0]  na6;
  logic [127:0] nb6, num7;
  logic [73:0]  den6, den7;
  logic [65:0]  r2_6, r2_7;
  logic         zero6, zero7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd6   <= sd5;
      den6  <= den5;
      r2_6  <= r2_5;
      zero6 <= zero5;
      na6   <= 84'(pp5[0]) + (84'(pp5[1]) << 22);
      nb6   <= (128'(pp5[2]) << 44) + (128'(pp5[3]) << 66);
      sd7   <= sd6;
      den7  <= den6;
      r2_7  <= r2_6;
      zero7 <= zero6;
      num7  <= 128'(na6) + nb6;
    end
  end

  // magnitude divider, one quotient bit a stage; root rides along
  div_t dst [0:QBits];

  always_ff @(posedge clk) begin
    if (rst) dst[0].v <= 1'b0;
    else if (en) begin
      dst[0].v    <= v7;
      dst[0].rem  <= num7;
      dst[0].q    <= '0;
      dst[0].cap  <= ({27'b0, num7} >= ({81'b0, den7} << QBits));
      dst[0].den  <= den7;
      dst[0].srem <= r2_7;
      dst[0].sres <= '0;
      dst[0].zero <= zero7;
      dst[0].side <= sd7;
    end
  end

  for (genvar k = 0; k < QBits; k++) begin : g_div
    localparam int I = QBits - 1 - k;
    logic [154:0]      dsh;
    logic              ge;
    logic [69:0]       trial;
    logic [SqBits-1:0] sbit;
    logic              sq_ge;
    div_t              nxt;

    assign dsh = {81'b0, dst[k].den} << I;
    assign ge  = {27'b0, dst[k].rem} >= dsh;

    if (k < SqBits) begin : g_sq
      localparam int B = SqBits - 1 - k;
      assign trial = (70'(dst[k].sres) << (B + 1)) + (70'(1) << (2 * B));
      assign sbit  = SqBits'(1) << B;
      assign sq_ge = {4'b0, dst[k].srem} >= trial;
    end else begin : g_nsq
      assign trial = '0;
      assign sbit  = '0;
      assign sq_ge = 1'b0;
    end

    always_comb begin
      nxt = dst[k];
      if (ge) begin
        nxt.rem = dst[k].rem - dsh[127:0];
        nxt.q   = dst[k].q | (QBits'(1) << I);
      end
      if (sq_ge) begin
        nxt.srem = dst[k].srem - trial[65:0];
        nxt.sres = dst[k].sres | sbit;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) dst[k+1].v <= 1'b0;
      else if (en) dst[k+1] <= nxt;
    end
  end

  // magnitude times offset, in partial products
  logic [81:0] mag;
  assign mag = dst[QBits].cap ? (82'(1) << QBits) : {1'b0, dst[QBits].q};

  logic              v9, v10;
  logic [60:0]       px9 [3], py9 [3];
  logic [114:0]      prx10, pry10;
  logic [SqBits-1:0] rr9, rr10;
  logic              nx9, ny9, zero9, nx10, ny10, zero10;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9  <= 1'b0;
      v10 <= 1'b0;
    end else if (en) begin
      v9  <= dst[QBits].v;
      v10 <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px9[0] <= 61'(mag[27:0])  * 61'(dst[QBits].side.adx);
      px9[1] <= 61'(mag[55:28]) * 61'(dst[QBits].side.adx);
      px9[2] <= 61'(mag[81:56]) * 61'(dst[QBits].side.adx);
      py9[0] <= 61'(mag[27:0])  * 61'(dst[QBits].side.ady);
      py9[1] <= 61'(mag[55:28]) * 61'(dst[QBits].side.ady);
      py9[2] <= 61'(mag[81:56]) * 61'(dst[QBits].side.ady);
      rr9    <= dst[QBits].sres;
      nx9    <= dst[QBits].side.nx;
      ny9    <= dst[QBits].side.ny;
      zero9  <= dst[QBits].zero;
      prx10  <= 115'(px9[0]) + (115'(px9[1]) << 28) + (115'(px9[2]) << 56);
      pry10  <= 115'(py9[0]) + (115'(py9[1]) << 28) + (115'(py9[2]) << 56);
      rr10   <= rr9;
      nx10   <= nx9;
      ny10   <= ny9;
      zero10 <= zero9;
    end
  end

  // component dividers, both lanes side by side
  comp_t cst [0:CBits];
  logic [114:0] rr_top;
  assign rr_top = 115'(rr10) << CBits;

  always_ff @(posedge clk) begin
    if (rst) cst[0].v <= 1'b0;
    else if (en) begin
      cst[0].v    <= v10;
      cst[0].remx <= prx10[81:0];
      cst[0].qx   <= '0;
      cst[0].ovfx <= (prx10 >= rr_top);
      cst[0].remy <= pry10[81:0];
      cst[0].qy   <= '0;
      cst[0].ovfy <= (pry10 >= rr_top);
      cst[0].rr   <= rr10;
      cst[0].nx   <= nx10;
      cst[0].ny   <= ny10;
      cst[0].zero <= zero10;
    end
  end

  for (genvar k = 0; k < CBits; k++) begin : g_comp
    localparam int I = CBits - 1 - k;
    logic [81:0] dsh;
    comp_t       nxt;

    assign dsh = 82'(cst[k].rr) << I;

    always_comb begin
      nxt = cst[k];
      if (cst[k].remx >= dsh) begin
        nxt.remx = cst[k].remx - dsh;
        nxt.qx   = cst[k].qx | (CBits'(1) << I);
      end
      if (cst[k].remy >= dsh) begin
        nxt.remy = cst[k].remy - dsh;
        nxt.qy   = cst[k].qy | (CBits'(1) << I);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) cst[k+1].v <= 1'b0;
      else if (en) cst[k+1] <= nxt;
    end
  end

  // clip, sign, zero-distance override
  logic [47:0] limx, limy, vx, vy;
  logic        satx, saty;

  always_comb begin
    limx = cst[CBits].nx ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    limy = cst[CBits].ny ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    satx = cst[CBits].ovfx || (cst[CBits].qx > limx);
    saty = cst[CBits].ovfy || (cst[CBits].qy > limy);
    vx   = satx ? limx : cst[CBits].qx;
    vy   = saty ? limy : cst[CBits].qy;
    if (cst[CBits].zero) begin
      res = '0;
    end else begin
      res.force_x   = cst[CBits].nx ? (~vx + 48'd1) : vx;
      res.force_y   = cst[CBits].ny ? (~vy + 48'd1) : vy;
      res.saturated = satx || saty;
    end
  end

  assign res_valid = cst[CBits].v;

endmodule
`default_nettype wire

/* src/point_mass_gravity_force.sv */
// Point-mass gravity force, 2D fixed point.
// probe_ch (sink): one item per probe, probe_x/probe_y signed Q16.16,
//   probe_mass unsigned integer. force_ch (source): one item per probe,
//   force_x/force_y signed 48-bit pulling toward the planet centre, and
//   saturated when either component was clipped.
// cfg_we/cfg_index/cfg_data write the planet registers (centre x, centre y,
//   radius, mass, G); indexes beyond the list are ignored. Write only when
//   no items are in flight.
// Throughput: one item per cycle while the skid register is empty. Items
//   pass through the 81-stage magnitude divider and the 48-stage component
//   dividers, plus product and sum stages, before force_ch.valid.
// A stalled receiver freezes the whole pipeline once the item leaving it
//   lands in a skid register, and probe_ch.ready drops until the skid
//   drains. Nothing is lost or repeated.
// Reset (synchronous) empties the pipeline and restores register defaults:
//   centre 0, radius 1.0, mass 0, G 0.
`default_nettype none
module point_mass_gravity_force (
  input  logic                            clk,
  input  logic                            rst,
  pmgf_probe_if.sink                      probe_ch,
  pmgf_force_if.source                    force_ch,
  input  logic                            cfg_we,
  input  logic [pmgf_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [pmgf_pkg::CfgDataW-1:0]   cfg_data
);
  import pmgf_pkg::*;

  pmgf_cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.centre_x      <= '0;
      cfg.centre_y      <= '0;
      cfg.planet_radius <= 31'd65536;
      cfg.planet_mass   <= '0;
      cfg.gravity_scale <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTRE_X:      cfg.centre_x      <= cfg_data[31:0];
        REG_CENTRE_Y:      cfg.centre_y      <= cfg_data[31:0];
        REG_PLANET_RADIUS: cfg.planet_radius <= cfg_data[30:0];
        REG_PLANET_MASS:   cfg.planet_mass   <= cfg_data[39:0];
        REG_GRAVITY_SCALE: cfg.gravity_scale <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  logic      en, core_v, push;
  pmgf_res_t core_res;
  logic      out_v, skid_v;
  pmgf_res_t out_d, skid_d;

  assign en             = !skid_v;
  assign probe_ch.ready = en;
  assign push           = core_v && en;

  pmgf_core u_core (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .cfg        (cfg),
    .in_valid   (probe_ch.valid),
    .probe_x    (probe_ch.probe_x),
    .probe_y    (probe_ch.probe_y),
    .probe_mass (probe_ch.probe_mass),
    .res_valid  (core_v),
    .res        (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (force_ch.ready || !out_v) begin
      out_v  <= skid_v || push;
      skid_v <= 1'b0;
    end else if (push) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (force_ch.ready || !out_v) begin
      out_d <= skid_v ? skid_d : core_res;
    end else if (push) begin
      skid_d <= core_res;
    end
  end

  assign force_ch.valid     = out_v;
  assign force_ch.force_x   = out_d.force_x;
  assign force_ch.force_y   = out_d.force_y;
  assign force_ch.saturated = out_d.saturated;

  // skid only ever holds an item behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_v)
    else $error("skid holds an item with no output item");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    (out_v && !force_ch.ready && push) |=> skid_v)
    else $error("item leaving pipeline during stall was dropped");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (skid_v && force_ch.ready) |=> (out_v && !skid_v))
    else $error("skid item not moved to output");

endmodule
`default_nettype wire

/* verif/pmgf_checker.sv */
`timescale 1ns / 100ps
`default_nettype none
module pmgf_checker (
  input  logic                          clk,
  input  logic                          rst,
  pmgf_probe_if                         probe_ch,
  pmgf_force_if                         force_ch,
  input  logic                          cfg_we,
  input  logic [pmgf_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [pmgf_pkg::CfgDataW-1:0] cfg_data,
  output int                            fail_count,
  output int                            pending,
  output int                            forces_seen,
  output int                            sat_seen
);
  import pmgf_pkg::*;

  pmgf_cfg_t planet;
  pmgf_res_t force_q[$];

  function automatic logic [47:0] axis_force(logic [127:0] mag, logic [33:0] d,
                                             logic [127:0] rr, ref logic clip);
    logic         neg;
    logic [127:0] ad;
    logic [127:0] c;
    logic [127:0] lim;
    logic [47:0]  v;
    neg = d[33];
    ad  = {94'd0, neg ? -d : d};
    lim = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
    c   = (mag * ad) / rr;
    if (c > lim) begin
      c    = lim;
      clip = 1'b1;
    end
    v = c[47:0];
    return neg ? -v : v;
  endfunction

  function automatic pmgf_res_t planet_pull(pmgf_cfg_t p, logic [31:0] px,
                                            logic [31:0] py, logic [39:0] pm);
    logic [33:0]  dx, dy, adx, ady;
    logic [127:0] r2, p2, num, den, mag, rr, cand;
    logic         clip;
    pmgf_res_t    res;
    dx  = {{2{p.centre_x[31]}}, p.centre_x} - {{2{px[31]}}, px};
    dy  = {{2{p.centre_y[31]}}, p.centre_y} - {{2{py[31]}}, py};
    adx = dx[33] ? -dx : dx;
    ady = dy[33] ? -dy : dy;
    r2  = 128'(adx) * 128'(adx) + 128'(ady) * 128'(ady);
    res = '0;
    if (r2 == 0) return res;
    p2  = 128'(p.planet_radius) * 128'(p.planet_radius);
    num = 128'(p.gravity_scale) * 128'(p.planet_mass) * 128'(pm);
    den = (r2 > p2) ? (r2 << 8) : p2 * 128'd2560;
    mag = num / den;
    // anything past 2^81 clips every nonzero component anyway
    if (mag > (128'd1 << 81)) mag = 128'd1 << 81;
    rr = 0;
    for (int b = 33; b >= 0; b--) begin
      cand = rr | (128'd1 << b);
      if (cand * cand <= r2) rr = cand;
    end
    clip = 1'b0;
    res.force_x   = axis_force(mag, dx, rr, clip);
    res.force_y   = axis_force(mag, dy, rr, clip);
    res.saturated = clip;
    return res;
  endfunction

  assign pending = force_q.size();

  always @(posedge clk) begin
    pmgf_res_t want;
    int        errs;
    errs = 0;
    if (rst) begin
      planet.centre_x      <= '0;
      planet.centre_y      <= '0;
      planet.planet_radius <= 31'd65536;
      planet.planet_mass   <= '0;
      planet.gravity_scale <= '0;
      force_q.delete();
      fail_count  <= 0;
      forces_seen <= 0;
      sat_seen    <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CENTRE_X:      planet.centre_x      <= cfg_data[31:0];
          REG_CENTRE_Y:      planet.centre_y      <= cfg_data[31:0];
          REG_PLANET_RADIUS: planet.planet_radius <= cfg_data[30:0];
          REG_PLANET_MASS:   planet.planet_mass   <= cfg_data[39:0];
          REG_GRAVITY_SCALE: planet.gravity_scale <= cfg_data[47:0];
          default: ;
        endcase
      end
      if (probe_ch.valid && probe_ch.ready)
        force_q.push_back(planet_pull(planet, probe_ch.probe_x, probe_ch.probe_y,
                                      probe_ch.probe_mass));
      if (force_ch.valid && force_ch.ready) begin
        forces_seen <= forces_seen + 1;
        if (force_ch.saturated) sat_seen <= sat_seen + 1;
        if (force_q.size() == 0) begin
          $error("force item with nothing expected");
          errs++;
        end else begin
          want = force_q.pop_front();
          if (force_ch.force_x !== want.force_x) begin
            $error("force_x: expected %h, got %h", want.force_x, force_ch.force_x);
            errs++;
          end
          if (force_ch.force_y !== want.force_y) begin
            $error("force_y: expected %h, got %h", want.force_y, force_ch.force_y);
            errs++;
          end
          if (force_ch.saturated !== want.saturated) begin
            $error("saturated: expected %b, got %b", want.saturated, force_ch.saturated);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end
endmodule
`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import pmgf_pkg::*;

  localparam int StallLimit = 5000;
  localparam int Drain      = 200;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  int   fail_count, pending, forces_seen, sat_seen;
  int   sent;
  int   idle_stall;
  logic quiet;
  logic long_hold_done;
  logic probe_took;
  logic [31:0] cx, cy;
  logic [30:0] rad;

  pmgf_probe_if probe_ch ();
  pmgf_force_if force_ch ();

  point_mass_gravity_force u_top (
    .clk(clk), .rst(rst), .probe_ch(probe_ch), .force_ch(force_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pmgf_checker u_checker (
    .clk(clk), .rst(rst), .probe_ch(probe_ch), .force_ch(force_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending),
    .forces_seen(forces_seen), .sat_seen(sat_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    probe_took <= probe_ch.valid && probe_ch.ready;
  end

  // watchdog: cycles with no item moving on either channel
  always @(posedge clk) begin
    if (rst || (probe_ch.valid && probe_ch.ready) || (force_ch.valid && force_ch.ready)) begin
      idle_stall <= 0;
    end else begin
      idle_stall <= idle_stall + 1;
      if (idle_stall >= StallLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, one long hold-off to back the pipe up
  initial begin
    force_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!long_hold_done && sent > 300) begin
        force_ch.ready = 1'b0;
        repeat (400) @(negedge clk);
        long_hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        force_ch.ready = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end else begin
        force_ch.ready = 1'b1;
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end
    end
  end

  function automatic logic [63:0] rnd_bits(int w);
    logic [63:0] v;
    v = {$urandom, $urandom};
    v = v >> $urandom_range(0, 63);
    return v & ((64'd1 << w) - 1);
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_planet(logic [31:0] x, logic [31:0] y, logic [30:0] r,
                            logic [39:0] m, logic [47:0] g);
    write_reg(REG_CENTRE_X, 48'(x));
    write_reg(REG_CENTRE_Y, 48'(y));
    write_reg(REG_PLANET_RADIUS, 48'(r));
    write_reg(REG_PLANET_MASS, 48'(m));
    write_reg(REG_GRAVITY_SCALE, g);
    // an index past the list must be ignored
    write_reg(REG_GRAVITY_SCALE + 3'd1, 48'({$urandom, $urandom}));
    cx  = x;
    cy  = y;
    rad = r;
  endtask

  task automatic settle();
    probe_ch.valid = 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (160) @(negedge clk);
  endtask

  task automatic send_probe(logic [31:0] x, logic [31:0] y, logic [39:0] m);
    if (!quiet && $urandom_range(0, 6) == 0) begin
      probe_ch.valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    probe_ch.valid      = 1'b1;
    probe_ch.probe_x    = x;
    probe_ch.probe_y    = y;
    probe_ch.probe_mass = m;
    @(negedge clk);
    while (!probe_took) @(negedge clk);
    sent++;
  endtask

  task automatic random_probe();
    logic [31:0] ox, oy;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      // near the planet: offsets of random width from the centre
      ox = 32'(rnd_bits($urandom_range(1, 32)));
      oy = 32'(rnd_bits($urandom_range(1, 32)));
      if ($urandom_range(0, 1)) ox = -ox;
      if ($urandom_range(0, 1)) oy = -oy;
      if (sel == 0) oy = 0;
      if (sel == 1) ox = 0;
      if (sel == 2 && rad != 0) begin
        ox = 32'($urandom_range(0, rad));
        oy = 0;
      end
      send_probe(cx + ox, cy + oy, 40'(rnd_bits(40)));
    end else begin
      send_probe($urandom, $urandom, 40'({$urandom, $urandom}));
    end
  endtask

  initial begin
    int phases;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    probe_ch.valid = 1'b0;
    probe_ch.probe_x    = '0;
    probe_ch.probe_y    = '0;
    probe_ch.probe_mass = '0;
    quiet          = 1'b0;
    long_hold_done = 1'b0;
    sent           = 0;
    phases         = 0;
    cx = 0; cy = 0; rad = 31'd65536;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // reset values: G and mass are zero, so every force is zero
    send_probe(32'h0001_0000, 32'h0, 40'hFF_FFFF_FFFF);
    send_probe(32'h0, 32'h0, 40'd5);
    settle();

    // G = 1.0, moderate mass
    set_planet(32'h0, 32'h0, 31'h1_0000, 40'd1000000, 48'h100_0000_0000);
    send_probe(32'h0, 32'h0, 40'd7);                  // on the centre
    send_probe(32'h0003_0000, 32'h0, 40'd50000);      // on an axis
    send_probe(32'h0, 32'hFFFD_0000, 40'd50000);
    send_probe(32'h0000_8000, 32'h0000_4000, 40'd1234567);  // inside
    send_probe(32'h0001_0000, 32'h0, 40'd999);        // on the boundary
    send_probe(32'h0001_0001, 32'h0, 40'd999);        // just outside
    send_probe(32'h7FFF_FFFF, 32'h8000_0000, 40'hFF_FFFF_FFFF);
    send_probe(32'h8000_0000, 32'h7FFF_FFFF, 40'd0);
    send_probe(32'h0000_0001, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
    settle();

    // everything at its top: huge magnitudes clip
    set_planet(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 40'hFF_FFFF_FFFF,
               48'hFFFF_FFFF_FFFF);
    send_probe(32'h7FFF_FFFF, 32'h8000_0000, 40'hFF_FFFF_FFFF);
    send_probe(32'h8000_0000, 32'h7FFF_FFFF, 40'hFF_FFFF_FFFF);
    send_probe(32'h7FFF_FFFE, 32'h8000_0001, 40'hFF_FFFF_FFFF);
    send_probe(32'h0, 32'h0, 40'd1);
    settle();

    // zero radius, centre at the minimum-x, maximum-y corner
    set_planet(32'h8000_0000, 32'h7FFF_FFFF, 31'd0, 40'd1, 48'd1);
    send_probe(32'h8000_0000, 32'h7FFF_FFFF, 40'd3);
    send_probe(32'h8000_0001, 32'h7FFF_FFFF, 40'hFF_FFFF_FFFF);
    send_probe(32'h7FFF_FFFF, 32'h8000_0000, 40'hFF_FFFF_FFFF);
    settle();

    for (int p = 0; p < 8; p++) begin
      if (p == 7) quiet = 1'b1;
      set_planet($urandom_range(0, 1) ? $urandom : 32'(rnd_bits(20)),
                 $urandom_range(0, 1) ? $urandom : 32'(rnd_bits(20)),
                 31'(rnd_bits(31)), 40'(rnd_bits(40)), 48'(rnd_bits(48)));
      for (int i = 0; i < 128; i++) random_probe();
      settle();
      phases++;
    end

    $display("%0d probes sent over %0d random planet settings plus directed cases;",
             sent, phases);
    $display("%0d forces checked, %0d of them clipped.", forces_seen, sat_seen);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
src/pmgf_pkg.sv
src/pmgf_if.sv
src/pmgf_core.sv
src/point_mass_gravity_force.sv
verif/pmgf_checker.sv
verif/testbench.sv
